FILE: hdl/bfu_pkg.sv
package bfu_pkg;

  // field and register widths
  localparam int FW        = 20;
  localparam int REG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int T_W       = 16;

  // datapath widths
  localparam int SUM_W = 32;
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = T_W + 1;
  localparam int DVD_W = 48;
  localparam int DVS_W = 24;
  localparam int SQ_W  = 42;
  localparam int SAT_W = 50;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VISUAL_RANGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_FACTOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_RIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_BOTTOM  = 3'd6;

  localparam logic [REG_W-1:0] RST_VISUAL_RANGE = 11'd75;
  localparam logic [REG_W-1:0] RST_MIN_DISTANCE = 11'd10;
  localparam logic [REG_W-1:0] RST_SPEED_LIMIT  = 11'd200;
  localparam logic [REG_W-1:0] RST_TURN_FACTOR  = 11'd15;
  localparam logic [REG_W-1:0] RST_EDGE_LOW     = 11'd68;
  localparam logic [REG_W-1:0] RST_EDGE_RIGHT   = 11'd781;
  localparam logic [REG_W-1:0] RST_EDGE_BOTTOM  = 11'd362;

  // opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // gain divisors: frame time scale times 1/gain
  localparam logic [DVS_W-1:0] COH_K = 24'd13107200;
  localparam logic [DVS_W-1:0] SEP_K = 24'd1310720;
  localparam logic [DVS_W-1:0] ALI_K = 24'd655360;

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((64'sd1 <<< (FW - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

  typedef logic signed [FW-1:0] fix_t;

  typedef struct packed {
    logic valid;
    fix_t px;
    fix_t py;
    fix_t vx;
    fix_t vy;
  } rec_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_DRAIN,
    ST_COH_AX,
    ST_COH_AY,
    ST_COH_MX,
    ST_COH_MY,
    ST_SEP_X,
    ST_SEP_Y,
    ST_ALI_AX,
    ST_ALI_AY,
    ST_ALI_X,
    ST_ALI_Y,
    ST_SQ_PREP,
    ST_SQRT,
    ST_LIM_X,
    ST_LIM_Y,
    ST_EDGE,
    ST_MOVE,
    ST_DONE
  } state_t;

  function automatic fix_t sat20(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return c[FW-1:0];
  endfunction

endpackage

FILE: hdl/bfu_cell.sv
// One bird slot of the ring; shifts toward slot zero while shift_en is high.
module bfu_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  logic          load_en,
  input  bfu_pkg::rec_t load_rec,
  input  bfu_pkg::rec_t prev_rec,
  output bfu_pkg::rec_t rec
);

  logic                valid_r;
  bfu_pkg::fix_t       px_r, py_r, vx_r, vy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_en) begin
      valid_r <= load_rec.valid;
    end else if (shift_en) begin
      valid_r <= prev_rec.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      px_r <= load_rec.px;
      py_r <= load_rec.py;
      vx_r <= load_rec.vx;
      vy_r <= load_rec.vy;
    end else if (shift_en) begin
      px_r <= prev_rec.px;
      py_r <= prev_rec.py;
      vx_r <= prev_rec.vx;
      vy_r <= prev_rec.vy;
    end
  end

  assign rec = '{valid: valid_r, px: px_r, py: py_r, vx: vx_r, vy: vy_r};

endmodule

FILE: hdl/bfu_div.sv
// Signed by unsigned divide, truncating toward zero; two quotient bits a cycle.
module bfu_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [bfu_pkg::DVD_W-1:0]    dividend,
  input  logic        [bfu_pkg::DVS_W-1:0]    divisor,
  output logic                                done,
  output logic signed [bfu_pkg::DVD_W-1:0]    quotient
);

  localparam int DW   = bfu_pkg::DVD_W;
  localparam int SW   = bfu_pkg::DVS_W;
  localparam int N_IT = DW / 2;
  localparam int CW   = $clog2(N_IT);

  logic          busy_r, done_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] num_r, num_s;
  logic [SW:0]   rem_r, rem_s;
  logic [SW-1:0] den_r;
  logic [DW-1:0] q_r;
  logic          last;

  always_comb begin
    num_s = num_r;
    rem_s = rem_r;
    for (int i = 0; i < 2; i++) begin
      rem_s = {rem_s[SW-1:0], num_s[DW-1]};
      num_s = {num_s[DW-2:0], 1'b0};
      if (rem_s >= {1'b0, den_r}) begin
        rem_s    = rem_s - {1'b0, den_r};
        num_s[0] = 1'b1;
      end
    end
  end

  assign last = busy_r && (cnt_r == CW'(N_IT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (last) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      neg_r <= dividend[DW-1];
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      num_r <= num_s;
      rem_r <= rem_s;
      if (last) q_r <= neg_r ? DW'(-num_s) : num_s;
    end
  end

  assign done     = done_r;
  assign quotient = $signed(q_r);

endmodule

FILE: hdl/bfu_sqrt.sv
// Integer square root, one root bit a cycle.
module bfu_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bfu_pkg::SQ_W-1:0]    radicand,
  output logic                        done,
  output logic [bfu_pkg::SQ_W/2-1:0]  root
);

  localparam int XW = bfu_pkg::SQ_W;
  localparam int RW = XW / 2;
  localparam int CW = $clog2(RW);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [XW-1:0] x_r;
  logic [RW+2:0] rem_r, rem_s, trial;
  logic [RW-1:0] root_r, root_s;
  logic          last;

  always_comb begin
    rem_s  = {rem_r[RW:0], x_r[XW-1:XW-2]};
    trial  = {1'b0, root_r, 2'b01};
    root_s = {root_r[RW-2:0], 1'b0};
    if (rem_s >= trial) begin
      rem_s     = rem_s - trial;
      root_s[0] = 1'b1;
    end
  end

  assign last = busy_r && (cnt_r == CW'(RW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (last) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[XW-3:0], 2'b00};
      rem_r  <= rem_s;
      root_r <= root_s;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: hdl/boids_flock_update_core.sv
// Channel   Ports                                  Handshake
// -------   -------------------------------------  ------------------------------
// input     in_opcode in_bird_index in_pos_x/y      word taken when start & !busy
//           in_vel_x/y in_frame_dt
// result    out_updated_index out_new_pos_x/y      word shown for one cycle,
//           out_new_vel_x/y                        marked by out_valid
// config    cfg_we cfg_index cfg_data              written when cfg_we is high
//
// A load word completes in the cycle it is taken; busy stays low.
// An update word keeps busy high until its result word is shown:
// the bird ring rotates once to fetch the bird and once more to gather the
// neighbor sums, then up to twelve divisions on the shared radix-4 divider (ten for
// the means and gains, two for the speed limit) and one square root on the
// bit-serial root unit follow.
// Reset clears the slot valid bits and restores register defaults; slot data
// is not cleared. The receiver cannot stall, so a result never waits.
module boids_flock_update_core #(
  parameter int MAX_BIRDS = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input word
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_opcode,
  input  logic [5:0]                          in_bird_index,
  input  logic signed [19:0]                  in_pos_x,
  input  logic signed [19:0]                  in_pos_y,
  input  logic signed [19:0]                  in_vel_x,
  input  logic signed [19:0]                  in_vel_y,
  input  logic [15:0]                         in_frame_dt,
  // result word
  output logic                                out_valid,
  output logic [5:0]                          out_updated_index,
  output logic signed [19:0]                  out_new_pos_x,
  output logic signed [19:0]                  out_new_pos_y,
  output logic signed [19:0]                  out_new_vel_x,
  output logic signed [19:0]                  out_new_vel_y,
  // configuration
  input  logic                                cfg_we,
  input  logic [bfu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfu_pkg::REG_W-1:0]           cfg_data
);

  localparam int FW     = bfu_pkg::FW;
  localparam int IDX_W  = $clog2(MAX_BIRDS);
  localparam int CNT_W  = $clog2(MAX_BIRDS + 1);
  localparam int L_W    = bfu_pkg::REG_W + FRAC_BITS;
  localparam int D2_W   = 2 * (FW + 1) + 1;
  localparam int CMP_W  = (2 * L_W > D2_W) ? 2 * L_W : D2_W;
  localparam int SUM_W  = bfu_pkg::SUM_W;
  localparam int SAT_W  = bfu_pkg::SAT_W;
  localparam int T_W    = bfu_pkg::T_W;
  localparam int RW     = bfu_pkg::SQ_W / 2;
  localparam int MV_W   = FW + T_W + 1;
  localparam int E_W    = 32;

  // ---------------------------------------------------------------- registers
  bfu_pkg::state_t state_r, state_nxt;

  logic [bfu_pkg::REG_W-1:0] vr_r, md_r, sl_r, tf_r, el_r, er_r, eb_r;

  logic [CNT_W-1:0] step_r, step_nxt;
  logic             run_r, run_nxt;

  logic [IDX_W-1:0]  idx_r;
  logic [T_W-1:0]    t_r;
  bfu_pkg::fix_t     px_r, py_r, vx_r, vy_r;
  bfu_pkg::fix_t     cax_r, cay_r, aax_r, aay_r;
  logic [2*L_W-1:0]  lv2_r, lm2_r;

  logic signed [SUM_W-1:0] csx_r, csy_r, ssx_r, ssy_r, asx_r, asy_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    self_in_r;

  logic [2*FW-1:0] sqx_r, sqy_r;
  logic [RW-1:0]   mag_r;

  // scan pipeline
  logic                     s1_v_r, s1_self_r, s2_v_r, s2_self_r;
  logic signed [FW:0]       s1_dx_r, s1_dy_r, s2_dx_r, s2_dy_r;
  bfu_pkg::fix_t            s1_wx_r, s1_wy_r, s1_vx_r, s1_vy_r;
  bfu_pkg::fix_t            s2_wx_r, s2_wy_r, s2_vx_r, s2_vy_r;
  logic [2*FW+1:0]          s2_d2x_r, s2_d2y_r;

  // ---------------------------------------------------------------- bird ring
  bfu_pkg::rec_t    cell_rec [MAX_BIRDS];
  bfu_pkg::rec_t    wr_rec;
  logic [MAX_BIRDS-1:0] slot_valid;
  logic             wr_en, shift_en;
  logic [IDX_W-1:0] wr_idx, in_idx;
  logic             in_ok, take, load_take, upd_take;

  for (genvar k = 0; k < MAX_BIRDS; k++) begin : g_cell
    bfu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .load_en  (wr_en && (wr_idx == IDX_W'(k))),
      .load_rec (wr_rec),
      .prev_rec (cell_rec[(k + 1) % MAX_BIRDS]),
      .rec      (cell_rec[k])
    );
    assign slot_valid[k] = cell_rec[k].valid;
  end

  assign in_ok     = (32'(in_bird_index) < 32'(MAX_BIRDS));
  assign in_idx    = IDX_W'(in_bird_index);
  assign take      = start && (state_r == bfu_pkg::ST_IDLE);
  assign load_take = take && in_ok && (in_opcode == bfu_pkg::OP_LOAD);
  // drop updates of empty or out-of-range slots
  assign upd_take  = take && in_ok && (in_opcode == bfu_pkg::OP_UPDATE) && slot_valid[in_idx];

  // ---------------------------------------------------------------- shared units
  logic                          div_start, div_done, sq_start, sq_done;
  logic signed [bfu_pkg::DVD_W-1:0] div_q;
  logic [bfu_pkg::DVS_W-1:0]     div_den;
  logic signed [bfu_pkg::MUL_A_W-1:0] mul_a;
  logic signed [bfu_pkg::MUL_B_W-1:0] mul_b;
  logic signed [bfu_pkg::MUL_A_W+bfu_pkg::MUL_B_W-1:0] mul_p;
  logic [RW-1:0]                 sq_root, sq_mag;

  assign mul_p = mul_a * mul_b;

  bfu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_p[bfu_pkg::DVD_W-1:0]),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  bfu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (bfu_pkg::SQ_W'(sqx_r) + bfu_pkg::SQ_W'(sqy_r)),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign sq_mag = sq_root >> FRAC_BITS;

  // ---------------------------------------------------------------- helpers
  function automatic bfu_pkg::fix_t whole(input bfu_pkg::fix_t x);
    logic signed [FW:0] s;
    s = {x[FW-1], x} + (x[FW-1] ? (FW+1)'((1 << FRAC_BITS) - 1) : (FW+1)'(0));
    s = s >>> FRAC_BITS;
    return s[FW-1:0];
  endfunction

  function automatic logic signed [SAT_W-1:0] sx(input logic signed [SAT_W-1:0] v);
    return v;
  endfunction

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vr_r <= bfu_pkg::RST_VISUAL_RANGE;
      md_r <= bfu_pkg::RST_MIN_DISTANCE;
      sl_r <= bfu_pkg::RST_SPEED_LIMIT;
      tf_r <= bfu_pkg::RST_TURN_FACTOR;
      el_r <= bfu_pkg::RST_EDGE_LOW;
      er_r <= bfu_pkg::RST_EDGE_RIGHT;
      eb_r <= bfu_pkg::RST_EDGE_BOTTOM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfu_pkg::REG_VISUAL_RANGE: vr_r <= cfg_data;
        bfu_pkg::REG_MIN_DISTANCE: md_r <= cfg_data;
        bfu_pkg::REG_SPEED_LIMIT:  sl_r <= cfg_data;
        bfu_pkg::REG_TURN_FACTOR:  tf_r <= cfg_data;
        bfu_pkg::REG_EDGE_LOW:     el_r <= cfg_data;
        bfu_pkg::REG_EDGE_RIGHT:   er_r <= cfg_data;
        bfu_pkg::REG_EDGE_BOTTOM:  eb_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- next state
  logic step_last, cnt_zero;
  assign step_last = (step_r == CNT_W'(MAX_BIRDS - 1));
  assign cnt_zero  = (cnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfu_pkg::ST_IDLE:    if (upd_take) state_nxt = bfu_pkg::ST_FETCH;
      bfu_pkg::ST_FETCH:   if (step_last) state_nxt = bfu_pkg::ST_SCAN;
      bfu_pkg::ST_SCAN:    if (step_last) state_nxt = bfu_pkg::ST_DRAIN;
      bfu_pkg::ST_DRAIN:   if (step_r == CNT_W'(1)) state_nxt = bfu_pkg::ST_COH_AX;
      bfu_pkg::ST_COH_AX: begin
        if (cnt_zero) state_nxt = bfu_pkg::ST_SEP_X;
        else if (run_r && div_done) state_nxt = bfu_pkg::ST_COH_AY;
      end
      bfu_pkg::ST_COH_AY:  if (run_r && div_done) state_nxt = bfu_pkg::ST_COH_MX;
      bfu_pkg::ST_COH_MX:  if (run_r && div_done) state_nxt = bfu_pkg::ST_COH_MY;
      bfu_pkg::ST_COH_MY:  if (run_r && div_done) state_nxt = bfu_pkg::ST_SEP_X;
      bfu_pkg::ST_SEP_X:   if (run_r && div_done) state_nxt = bfu_pkg::ST_SEP_Y;
      bfu_pkg::ST_SEP_Y:   if (run_r && div_done) state_nxt = bfu_pkg::ST_ALI_AX;
      bfu_pkg::ST_ALI_AX: begin
        if (cnt_zero) state_nxt = bfu_pkg::ST_SQ_PREP;
        else if (run_r && div_done) state_nxt = bfu_pkg::ST_ALI_AY;
      end
      bfu_pkg::ST_ALI_AY:  if (run_r && div_done) state_nxt = bfu_pkg::ST_ALI_X;
      bfu_pkg::ST_ALI_X:   if (run_r && div_done) state_nxt = bfu_pkg::ST_ALI_Y;
      bfu_pkg::ST_ALI_Y:   if (run_r && div_done) state_nxt = bfu_pkg::ST_SQ_PREP;
      bfu_pkg::ST_SQ_PREP: state_nxt = bfu_pkg::ST_SQRT;
      bfu_pkg::ST_SQRT: begin
        if (run_r && sq_done) begin
          state_nxt = (sq_mag > RW'(sl_r)) ? bfu_pkg::ST_LIM_X : bfu_pkg::ST_EDGE;
        end
      end
      bfu_pkg::ST_LIM_X:   if (run_r && div_done) state_nxt = bfu_pkg::ST_LIM_Y;
      bfu_pkg::ST_LIM_Y:   if (run_r && div_done) state_nxt = bfu_pkg::ST_EDGE;
      bfu_pkg::ST_EDGE:    state_nxt = bfu_pkg::ST_MOVE;
      bfu_pkg::ST_MOVE:    state_nxt = bfu_pkg::ST_DONE;
      bfu_pkg::ST_DONE:    state_nxt = bfu_pkg::ST_IDLE;
      default:             state_nxt = bfu_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  logic div_state;

  always_comb begin
    div_state = 1'b0;
    shift_en  = 1'b0;
    sq_start  = 1'b0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      bfu_pkg::ST_IDLE:  busy = 1'b0;
      bfu_pkg::ST_FETCH, bfu_pkg::ST_SCAN: shift_en = 1'b1;
      bfu_pkg::ST_COH_AX, bfu_pkg::ST_ALI_AX: div_state = !cnt_zero;
      bfu_pkg::ST_COH_AY, bfu_pkg::ST_COH_MX, bfu_pkg::ST_COH_MY,
      bfu_pkg::ST_SEP_X, bfu_pkg::ST_SEP_Y, bfu_pkg::ST_ALI_AY,
      bfu_pkg::ST_ALI_X, bfu_pkg::ST_ALI_Y, bfu_pkg::ST_LIM_X,
      bfu_pkg::ST_LIM_Y: div_state = 1'b1;
      bfu_pkg::ST_SQRT:  sq_start = !run_r;
      bfu_pkg::ST_DONE:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assign div_start = div_state && !run_r;
  assign run_nxt   = (div_start || sq_start) ? 1'b1 : ((div_done || sq_done) ? 1'b0 : run_r);

  // write back on completion, else take loads straight from the port
  assign wr_en  = load_take || out_valid;
  assign wr_idx = out_valid ? idx_r : in_idx;
  assign wr_rec = out_valid ? '{valid: 1'b1, px: px_r, py: py_r, vx: vx_r, vy: vy_r}
                            : '{valid: 1'b1, px: in_pos_x, py: in_pos_y,
                                vx: in_vel_x, vy: in_vel_y};

  always_comb begin
    step_nxt = '0;
    if (shift_en) begin
      step_nxt = step_last ? '0 : step_r + CNT_W'(1);
    end else if (state_r == bfu_pkg::ST_DRAIN) begin
      step_nxt = (step_r == CNT_W'(1)) ? '0 : step_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfu_pkg::ST_IDLE;
      step_r  <= '0;
      run_r   <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      run_r   <= run_nxt;
      s1_v_r  <= (state_r == bfu_pkg::ST_SCAN) && cell_rec[0].valid;
      s2_v_r  <= s1_v_r;
    end
  end

  // ---------------------------------------------------------------- multiplier and divisor select
  always_comb begin
    mul_a   = '0;
    mul_b   = bfu_pkg::MUL_B_W'(1);
    div_den = bfu_pkg::DVS_W'(cnt_r);
    case (state_r)
      bfu_pkg::ST_COH_AX: mul_a = csx_r;
      bfu_pkg::ST_COH_AY: mul_a = csy_r;
      bfu_pkg::ST_COH_MX: begin
        mul_a   = (bfu_pkg::MUL_A_W'(cax_r) <<< FRAC_BITS) - bfu_pkg::MUL_A_W'(px_r);
        mul_b   = $signed({1'b0, t_r});
        div_den = bfu_pkg::COH_K;
      end
      bfu_pkg::ST_COH_MY: begin
        mul_a   = (bfu_pkg::MUL_A_W'(cay_r) <<< FRAC_BITS) - bfu_pkg::MUL_A_W'(py_r);
        mul_b   = $signed({1'b0, t_r});
        div_den = bfu_pkg::COH_K;
      end
      bfu_pkg::ST_SEP_X: begin
        mul_a   = ssx_r;
        mul_b   = $signed({1'b0, t_r});
        div_den = bfu_pkg::SEP_K;
      end
      bfu_pkg::ST_SEP_Y: begin
        mul_a   = ssy_r;
        mul_b   = $signed({1'b0, t_r});
        div_den = bfu_pkg::SEP_K;
      end
      bfu_pkg::ST_ALI_AX: mul_a = asx_r + (self_in_r ? SUM_W'(vx_r) : SUM_W'(0));
      bfu_pkg::ST_ALI_AY: mul_a = asy_r + (self_in_r ? SUM_W'(vy_r) : SUM_W'(0));
      bfu_pkg::ST_ALI_X: begin
        mul_a   = bfu_pkg::MUL_A_W'(aax_r) - bfu_pkg::MUL_A_W'(vx_r);
        mul_b   = $signed({1'b0, t_r});
        div_den = bfu_pkg::ALI_K;
      end
      bfu_pkg::ST_ALI_Y: begin
        mul_a   = bfu_pkg::MUL_A_W'(aay_r) - bfu_pkg::MUL_A_W'(vy_r);
        mul_b   = $signed({1'b0, t_r});
        div_den = bfu_pkg::ALI_K;
      end
      bfu_pkg::ST_LIM_X: begin
        mul_a   = bfu_pkg::MUL_A_W'(vx_r);
        mul_b   = $signed(bfu_pkg::MUL_B_W'(sl_r));
        div_den = bfu_pkg::DVS_W'(mag_r);
      end
      bfu_pkg::ST_LIM_Y: begin
        mul_a   = bfu_pkg::MUL_A_W'(vy_r);
        mul_b   = $signed(bfu_pkg::MUL_B_W'(sl_r));
        div_den = bfu_pkg::DVS_W'(mag_r);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- edge turns and move
  logic signed [E_W-1:0]  lo_e, rt_e, bt_e, tf_e, px_e, py_e;
  bfu_pkg::fix_t          vx_e1, vx_e2, vy_e1, vy_e2;
  logic signed [MV_W-1:0] mvx, mvy, mvx_r, mvy_r;

  always_comb begin
    lo_e  = $signed(E_W'(el_r)) <<< FRAC_BITS;
    rt_e  = $signed(E_W'(er_r)) <<< FRAC_BITS;
    bt_e  = $signed(E_W'(eb_r)) <<< FRAC_BITS;
    tf_e  = $signed(E_W'(tf_r)) <<< FRAC_BITS;
    px_e  = E_W'(px_r);
    py_e  = E_W'(py_r);
    vx_e1 = (px_e < lo_e) ? bfu_pkg::sat20(sx(SAT_W'(vx_r)) + SAT_W'(tf_e)) : vx_r;
    vx_e2 = (px_e > rt_e) ? bfu_pkg::sat20(sx(SAT_W'(vx_e1)) - SAT_W'(tf_e)) : vx_e1;
    vy_e1 = (py_e < lo_e) ? bfu_pkg::sat20(sx(SAT_W'(vy_r)) + SAT_W'(tf_e)) : vy_r;
    vy_e2 = (py_e > bt_e) ? bfu_pkg::sat20(sx(SAT_W'(vy_e1)) - SAT_W'(tf_e)) : vy_e1;
    // truncate velocity times frame time toward zero
    mvx   = MV_W'(vx_r) * $signed({{(MV_W-T_W){1'b0}}, t_r});
    mvy   = MV_W'(vy_r) * $signed({{(MV_W-T_W){1'b0}}, t_r});
    mvx_r = $signed(mvx + (mvx[MV_W-1] ? MV_W'({T_W{1'b1}}) : MV_W'(0))) >>> T_W;
    mvy_r = $signed(mvy + (mvy[MV_W-1] ? MV_W'({T_W{1'b1}}) : MV_W'(0))) >>> T_W;
  end

  // ---------------------------------------------------------------- scan pipeline
  logic [D2_W-1:0] d2;
  logic            in_vis, in_min;

  assign d2     = D2_W'(s2_d2x_r) + D2_W'(s2_d2y_r);
  assign in_vis = CMP_W'(d2) < CMP_W'(lv2_r);
  assign in_min = CMP_W'(d2) < CMP_W'(lm2_r);

  always_ff @(posedge clk) begin
    // stage one: differences against the head of the ring
    s1_self_r <= (step_r[IDX_W-1:0] == idx_r);
    s1_dx_r   <= (FW+1)'(px_r) - (FW+1)'(cell_rec[0].px);
    s1_dy_r   <= (FW+1)'(py_r) - (FW+1)'(cell_rec[0].py);
    s1_wx_r   <= whole(cell_rec[0].px);
    s1_wy_r   <= whole(cell_rec[0].py);
    s1_vx_r   <= cell_rec[0].vx;
    s1_vy_r   <= cell_rec[0].vy;
    // stage two: squares
    s2_self_r <= s1_self_r;
    s2_dx_r   <= s1_dx_r;
    s2_dy_r   <= s1_dy_r;
    s2_d2x_r  <= (2*FW+2)'(s1_dx_r * s1_dx_r);
    s2_d2y_r  <= (2*FW+2)'(s1_dy_r * s1_dy_r);
    s2_wx_r   <= s1_wx_r;
    s2_wy_r   <= s1_wy_r;
    s2_vx_r   <= s1_vx_r;
    s2_vy_r   <= s1_vy_r;
  end

  // ---------------------------------------------------------------- working registers
  always_ff @(posedge clk) begin
    if (upd_take) begin
      idx_r <= in_idx;
      t_r   <= in_frame_dt;
    end
    case (state_r)
      bfu_pkg::ST_FETCH: begin
        // capture own record as it passes the head; clear the sums
        if (step_r[IDX_W-1:0] == idx_r) begin
          px_r <= cell_rec[0].px;
          py_r <= cell_rec[0].py;
          vx_r <= cell_rec[0].vx;
          vy_r <= cell_rec[0].vy;
        end
        lv2_r     <= (2*L_W)'({vr_r, FRAC_BITS'(0)} * {vr_r, FRAC_BITS'(0)});
        lm2_r     <= (2*L_W)'({md_r, FRAC_BITS'(0)} * {md_r, FRAC_BITS'(0)});
        csx_r     <= '0;
        csy_r     <= '0;
        ssx_r     <= '0;
        ssy_r     <= '0;
        asx_r     <= '0;
        asy_r     <= '0;
        cnt_r     <= '0;
        self_in_r <= 1'b0;
      end
      bfu_pkg::ST_SCAN, bfu_pkg::ST_DRAIN: begin
        if (s2_v_r) begin
          if (in_vis) begin
            cnt_r <= cnt_r + CNT_W'(1);
            csx_r <= csx_r + SUM_W'(s2_wx_r);
            csy_r <= csy_r + SUM_W'(s2_wy_r);
            if (s2_self_r) begin
              self_in_r <= 1'b1;
            end else begin
              asx_r <= asx_r + SUM_W'(s2_vx_r);
              asy_r <= asy_r + SUM_W'(s2_vy_r);
            end
          end
          if (in_min && !s2_self_r) begin
            ssx_r <= ssx_r + SUM_W'(s2_dx_r);
            ssy_r <= ssy_r + SUM_W'(s2_dy_r);
          end
        end
      end
      bfu_pkg::ST_COH_AX: if (div_done) cax_r <= div_q[FW-1:0];
      bfu_pkg::ST_COH_AY: if (div_done) cay_r <= div_q[FW-1:0];
      bfu_pkg::ST_ALI_AX: if (div_done) aax_r <= div_q[FW-1:0];
      bfu_pkg::ST_ALI_AY: if (div_done) aay_r <= div_q[FW-1:0];
      bfu_pkg::ST_COH_MX, bfu_pkg::ST_SEP_X, bfu_pkg::ST_ALI_X: begin
        if (div_done) vx_r <= bfu_pkg::sat20(sx(SAT_W'(vx_r)) + SAT_W'(div_q));
      end
      bfu_pkg::ST_COH_MY, bfu_pkg::ST_SEP_Y, bfu_pkg::ST_ALI_Y: begin
        if (div_done) vy_r <= bfu_pkg::sat20(sx(SAT_W'(vy_r)) + SAT_W'(div_q));
      end
      bfu_pkg::ST_SQ_PREP: begin
        sqx_r <= (2*FW)'(vx_r * vx_r);
        sqy_r <= (2*FW)'(vy_r * vy_r);
      end
      bfu_pkg::ST_SQRT:  if (sq_done) mag_r <= sq_mag;
      bfu_pkg::ST_LIM_X: if (div_done) vx_r <= div_q[FW-1:0];
      bfu_pkg::ST_LIM_Y: if (div_done) vy_r <= div_q[FW-1:0];
      bfu_pkg::ST_EDGE: begin
        vx_r <= vx_e2;
        vy_r <= vy_e2;
      end
      bfu_pkg::ST_MOVE: begin
        px_r <= bfu_pkg::sat20(sx(SAT_W'(px_r)) + SAT_W'(mvx_r));
        py_r <= bfu_pkg::sat20(sx(SAT_W'(py_r)) + SAT_W'(mvy_r));
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result word
  assign out_updated_index = 6'(idx_r);
  assign out_new_pos_x     = px_r;
  assign out_new_pos_y     = py_r;
  assign out_new_vel_x     = vx_r;
  assign out_new_vel_y     = vy_r;

endmodule

FILE: hdl/bfu_checker.sv
module bfu_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_opcode,
  input logic out_valid
);

  // a result only closes an update in progress
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside an update");

  // one result per update, then idle
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("result not followed by idle");

  // a load never occupies the block
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_opcode == bfu_pkg::OP_LOAD)) |=> !busy)
    else $error("load left the block busy");

  // busy only rises on an accepted word
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start)) else $error("busy without a word");

endmodule

bind boids_flock_update_core bfu_checker u_bfu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_opcode (in_opcode),
  .out_valid (out_valid)
);

FILE: tb/sv/tb.sv
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  BIRDS      = 64;
  localparam int  NUM_REGS   = 7;
  localparam longint ONE_PX  = 256;
  localparam longint DT_ONE  = 65536;
  localparam longint LIMIT   = 20_000_000;
  // an update walks the flock and runs up to twelve divisions: leave room for the longest
  localparam int  SETTLE     = 600;

  // one input word, held in the block's own field types
  typedef struct {
    logic       op;
    logic [5:0] slot;
    bfu_pkg::fix_t px;
    bfu_pkg::fix_t py;
    bfu_pkg::fix_t vx;
    bfu_pkg::fix_t vy;
    logic [15:0] dt;
  } flock_word_t;

  // one updated bird record as the block reports it
  typedef struct {
    logic [5:0] slot;
    bfu_pkg::fix_t px;
    bfu_pkg::fix_t py;
    bfu_pkg::fix_t vx;
    bfu_pkg::fix_t vy;
  } bird_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = bfu_pkg::OP_LOAD;
  logic [5:0] in_bird_index = '0;
  logic signed [19:0] in_pos_x = '0;
  logic signed [19:0] in_pos_y = '0;
  logic signed [19:0] in_vel_x = '0;
  logic signed [19:0] in_vel_y = '0;
  logic [15:0] in_frame_dt = '0;
  logic out_valid;
  logic [5:0] out_updated_index;
  logic signed [19:0] out_new_pos_x;
  logic signed [19:0] out_new_pos_y;
  logic signed [19:0] out_new_vel_x;
  logic signed [19:0] out_new_vel_y;
  logic cfg_we = 1'b0;
  logic [bfu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bfu_pkg::REG_W-1:0] cfg_data = '0;

  boids_flock_update_core i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow flock and register file used by the bird predictor
  longint flock_px[BIRDS];
  longint flock_py[BIRDS];
  longint flock_vx[BIRDS];
  longint flock_vy[BIRDS];
  bit     flock_valid[BIRDS];
  longint reg_val[NUM_REGS];

  bird_rec_t pending_birds[$];
  int     errors = 0;
  longint cycles = 0;

  // Clamp to the 20-bit signed field range
  function automatic longint clamp20(input longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  // Floor square root, digit by digit
  function automatic longint root_floor(input longint x);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // True when the distance between the two positions is below lim pixels
  function automatic bit in_reach(input longint ax, input longint ay,
                                  input longint bx, input longint by, input longint lim);
    longint dx;
    longint dy;
    longint l;
    dx = ax - bx;
    dy = ay - by;
    l = lim * ONE_PX;
    return (dx * dx + dy * dy) < l * l;
  endfunction

  // Apply one word to the shadow flock; return 1 with the updated bird when it reports
  function automatic bit fly_bird(input flock_word_t w, output bird_rec_t r);
    int     s;
    int     j;
    longint px, py, vx, vy, t, sx, sy, n, ax, ay, mag;
    s = w.slot;
    r = '{default: '0};
    if (w.op == bfu_pkg::OP_LOAD) begin
      flock_px[s] = w.px;
      flock_py[s] = w.py;
      flock_vx[s] = w.vx;
      flock_vy[s] = w.vy;
      flock_valid[s] = 1'b1;
      return 1'b0;
    end
    if (!flock_valid[s]) return 1'b0;
    px = flock_px[s];
    py = flock_py[s];
    vx = flock_vx[s];
    vy = flock_vy[s];
    t = w.dt;

    // cohesion toward the mean whole-pixel position
    sx = 0; sy = 0; n = 0;
    for (j = 0; j < BIRDS; j++) begin
      if (flock_valid[j] && in_reach(px, py, flock_px[j], flock_py[j],
                                     reg_val[bfu_pkg::REG_VISUAL_RANGE])) begin
        sx += flock_px[j] / ONE_PX;
        sy += flock_py[j] / ONE_PX;
        n++;
      end
    end
    if (n > 0) begin
      vx = clamp20(vx + ((sx / n) * ONE_PX - px) * t / (200 * DT_ONE));
      vy = clamp20(vy + ((sy / n) * ONE_PX - py) * t / (200 * DT_ONE));
    end

    // separation from close neighbors
    sx = 0; sy = 0;
    for (j = 0; j < BIRDS; j++) begin
      if (flock_valid[j] && j != s &&
          in_reach(px, py, flock_px[j], flock_py[j], reg_val[bfu_pkg::REG_MIN_DISTANCE])) begin
        sx += px - flock_px[j];
        sy += py - flock_py[j];
      end
    end
    vx = clamp20(vx + sx * t / (20 * DT_ONE));
    vy = clamp20(vy + sy * t / (20 * DT_ONE));

    // alignment, own velocity taken at its working value
    sx = 0; sy = 0; n = 0;
    for (j = 0; j < BIRDS; j++) begin
      if (flock_valid[j] && in_reach(px, py, flock_px[j], flock_py[j],
                                     reg_val[bfu_pkg::REG_VISUAL_RANGE])) begin
        sx += (j == s) ? vx : flock_vx[j];
        sy += (j == s) ? vy : flock_vy[j];
        n++;
      end
    end
    if (n > 0) begin
      ax = sx / n;
      ay = sy / n;
      vx = clamp20(vx + (ax - vx) * t / (10 * DT_ONE));
      vy = clamp20(vy + (ay - vy) * t / (10 * DT_ONE));
    end

    // speed limit
    mag = root_floor(vx * vx + vy * vy) >>> 8;
    if (mag > reg_val[bfu_pkg::REG_SPEED_LIMIT]) begin
      vx = vx * reg_val[bfu_pkg::REG_SPEED_LIMIT] / mag;
      vy = vy * reg_val[bfu_pkg::REG_SPEED_LIMIT] / mag;
    end

    // edge turns, tested on the position before the move
    if (px < reg_val[bfu_pkg::REG_EDGE_LOW] * ONE_PX)
      vx = clamp20(vx + reg_val[bfu_pkg::REG_TURN_FACTOR] * ONE_PX);
    if (px > reg_val[bfu_pkg::REG_EDGE_RIGHT] * ONE_PX)
      vx = clamp20(vx - reg_val[bfu_pkg::REG_TURN_FACTOR] * ONE_PX);
    if (py < reg_val[bfu_pkg::REG_EDGE_LOW] * ONE_PX)
      vy = clamp20(vy + reg_val[bfu_pkg::REG_TURN_FACTOR] * ONE_PX);
    if (py > reg_val[bfu_pkg::REG_EDGE_BOTTOM] * ONE_PX)
      vy = clamp20(vy - reg_val[bfu_pkg::REG_TURN_FACTOR] * ONE_PX);

    px = clamp20(px + vx * t / DT_ONE);
    py = clamp20(py + vy * t / DT_ONE);
    flock_px[s] = px;
    flock_py[s] = py;
    flock_vx[s] = vx;
    flock_vy[s] = vy;
    r.slot = w.slot;
    r.px = bfu_pkg::fix_t'(px);
    r.py = bfu_pkg::fix_t'(py);
    r.vx = bfu_pkg::fix_t'(vx);
    r.vy = bfu_pkg::fix_t'(vy);
    return 1'b1;
  endfunction

  // Watchdog: give up far beyond the slowest correct run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("boids_flock_update_core test failed");
      $finish;
    end
  end

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Take each result word as it is strobed and match it against the oldest expected bird
  always @(posedge clk) begin
    bird_rec_t e;
    if (rst_n && out_valid) begin
      if (pending_birds.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, actual slot %0d",
                 $time, out_updated_index);
      end else begin
        e = pending_birds.pop_front();
        check_field("updated_index", e.slot, out_updated_index);
        check_field("new_pos_x", e.px, out_new_pos_x);
        check_field("new_pos_y", e.py, out_new_pos_y);
        check_field("new_vel_x", e.vx, out_new_vel_x);
        check_field("new_vel_y", e.vy, out_new_vel_y);
      end
    end
  end

  // Present one word and hold it until the block takes it; start stays high for the caller
  task automatic send_word(input flock_word_t w);
    bird_rec_t r;
    start <= 1'b1;
    in_opcode <= w.op;
    in_bird_index <= w.slot;
    in_pos_x <= w.px;
    in_pos_y <= w.py;
    in_vel_x <= w.vx;
    in_vel_y <= w.vy;
    in_frame_dt <= w.dt;
    do @(posedge clk); while (busy);
    if (fly_bird(w, r)) pending_birds.push_back(r);
  endtask

  // Drop start for a random gap: mostly none or short, now and then long
  task automatic idle_gap();
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    gap = (roll < 55) ? 0 : (roll < 90) ? $urandom_range(1, 4) : $urandom_range(20, 600);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lower start and wait until every expected bird is back and the block is idle
  task automatic drain_flock();
    start <= 1'b0;
    @(posedge clk);
    while (pending_birds.size() != 0) @(posedge clk);
    // an update of an empty slot reports nothing and leaves the block idle
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write the whole register file back to back, with an optional stray index
  task automatic write_regs(input longint v[NUM_REGS], input bit stray);
    int k;
    for (k = 0; k < NUM_REGS; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= bfu_pkg::CFG_IDX_W'(k);
      cfg_data <= bfu_pkg::REG_W'(v[k]);
      @(posedge clk);
      reg_val[k] = v[k] & 11'h7FF;
    end
    if (stray) begin
      // index past the last register: the block must ignore it
      cfg_we <= 1'b1;
      cfg_index <= bfu_pkg::CFG_IDX_W'(NUM_REGS);
      cfg_data <= bfu_pkg::REG_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bfu_pkg::fix_t pix(input int p, input int frac);
    return bfu_pkg::fix_t'(p * ONE_PX + frac);
  endfunction

  function automatic bfu_pkg::fix_t rand_pos();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return pix($urandom_range(0, 300), $urandom_range(0, 255));
    if (roll < 90) return pix(int'($urandom_range(0, 1100)) - 100, $urandom_range(0, 255));
    return bfu_pkg::fix_t'($urandom);
  endfunction

  function automatic bfu_pkg::fix_t rand_vel();
    if ($urandom_range(0, 99) < 85)
      return bfu_pkg::fix_t'(int'($urandom_range(0, 204800)) - 102400);
    return bfu_pkg::fix_t'($urandom);
  endfunction

  function automatic logic [15:0] rand_dt();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 16'($urandom_range(0, 2000));
    if (roll < 90) return 16'($urandom);
    return (roll < 95) ? 16'd0 : 16'hFFFF;
  endfunction

  // Loads and updates with random content; updates mostly aim at loaded birds
  function automatic flock_word_t rand_word();
    flock_word_t w;
    int tries;
    w.op = ($urandom_range(0, 99) < 35) ? bfu_pkg::OP_LOAD : bfu_pkg::OP_UPDATE;
    w.slot = 6'($urandom);
    if (w.op == bfu_pkg::OP_UPDATE && $urandom_range(0, 99) < 85) begin
      for (tries = 0; tries < 16 && !flock_valid[w.slot]; tries++) w.slot = 6'($urandom);
    end
    w.px = rand_pos();
    w.py = rand_pos();
    w.vx = rand_vel();
    w.vy = rand_vel();
    w.dt = rand_dt();
    return w;
  endfunction

  // Random traffic; some stretches run back to back with no gaps at all
  task automatic run_random(input int count);
    int k;
    bit no_gaps;
    no_gaps = 1'b0;
    for (k = 0; k < count; k++) begin
      if (k % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      send_word(rand_word());
      if (!no_gaps) idle_gap();
    end
  endtask

  function automatic flock_word_t mk(input logic op, input int slot, input bfu_pkg::fix_t px,
                                     input bfu_pkg::fix_t py, input bfu_pkg::fix_t vx,
                                     input bfu_pkg::fix_t vy, input int dt);
    flock_word_t w;
    w.op = op;
    w.slot = 6'(slot);
    w.px = px;
    w.py = py;
    w.vx = vx;
    w.vy = vy;
    w.dt = 16'(dt);
    return w;
  endfunction

  // Directed words at reset defaults: empty slot, field extremes, a close cluster,
  // birds past every edge and one far over the speed limit
  task automatic test_directed();
    longint dflt[NUM_REGS];
    bfu_pkg::fix_t hi;
    bfu_pkg::fix_t lo;
    hi = bfu_pkg::fix_t'(524287);
    lo = bfu_pkg::fix_t'(-524288);
    dflt = '{75, 10, 200, 15, 68, 781, 362};
    write_regs(dflt, 1'b1);
    send_word(mk(bfu_pkg::OP_UPDATE, 5, '0, '0, '0, '0, 1000));
    send_word(mk(bfu_pkg::OP_LOAD, 0, hi, lo, hi, lo, 0));
    send_word(mk(bfu_pkg::OP_LOAD, 63, lo, hi, lo, hi, 65535));
    send_word(mk(bfu_pkg::OP_UPDATE, 0, '0, '0, '0, '0, 65535));
    send_word(mk(bfu_pkg::OP_UPDATE, 63, '0, '0, '0, '0, 0));
    send_word(mk(bfu_pkg::OP_UPDATE, 63, '0, '0, '0, '0, 65535));
    send_word(mk(bfu_pkg::OP_LOAD, 1, pix(100, 0), pix(100, 0), pix(30, 0), pix(-5, 7), 0));
    send_word(mk(bfu_pkg::OP_LOAD, 2, pix(103, 128), pix(100, 0), pix(-20, 3), pix(10, 0), 0));
    send_word(mk(bfu_pkg::OP_LOAD, 3, pix(100, 0), pix(104, 9), pix(5, 0), pix(40, 0), 0));
    send_word(mk(bfu_pkg::OP_LOAD, 4, pix(790, 0), pix(370, 0), pix(50, 0), pix(60, 0), 0));
    send_word(mk(bfu_pkg::OP_LOAD, 10, pix(20, 0), pix(20, 0), pix(-1000, 0), pix(900, 0), 0));
    send_word(mk(bfu_pkg::OP_UPDATE, 1, '0, '0, '0, '0, 6554));
    send_word(mk(bfu_pkg::OP_UPDATE, 2, '0, '0, '0, '0, 6554));
    send_word(mk(bfu_pkg::OP_UPDATE, 3, '0, '0, '0, '0, 65535));
    send_word(mk(bfu_pkg::OP_UPDATE, 4, '0, '0, '0, '0, 6554));
    send_word(mk(bfu_pkg::OP_UPDATE, 10, '0, '0, '0, '0, 65535));
    send_word(mk(bfu_pkg::OP_UPDATE, 10, '0, '0, '0, '0, 1));
    drain_flock();
  endtask

  // Defaults with random traffic; pause midway until the flock is fully reported
  task automatic test_defaults();
    run_random(300);
    drain_flock();
    run_random(300);
    drain_flock();
  endtask

  // All registers at zero: no neighbors at all, any speed of a whole pixel or more forced to zero
  task automatic test_regs_low();
    longint v[NUM_REGS];
    v = '{0, 0, 0, 0, 0, 0, 0};
    write_regs(v, 1'b0);
    run_random(250);
    drain_flock();
  endtask

  // All registers at their top: whole cluster in range, every bird below pixel 2047 past the low edge
  task automatic test_regs_high();
    longint v[NUM_REGS];
    v = '{2047, 2047, 2047, 2047, 2047, 2047, 2047};
    write_regs(v, 1'b1);
    run_random(250);
    drain_flock();
  endtask

  // Several random settings, each written with the block idle
  task automatic test_regs_random();
    longint v[NUM_REGS];
    int p;
    int k;
    for (p = 0; p < 4; p++) begin
      for (k = 0; k < NUM_REGS; k++) v[k] = $urandom_range(0, 2047);
      // keep some settings in the useful neighborhood of the defaults
      if (p % 2 == 0) begin
        v[bfu_pkg::REG_VISUAL_RANGE] = $urandom_range(20, 150);
        v[bfu_pkg::REG_MIN_DISTANCE] = $urandom_range(2, 40);
        v[bfu_pkg::REG_SPEED_LIMIT] = $urandom_range(1, 400);
        v[bfu_pkg::REG_EDGE_LOW] = $urandom_range(0, 120);
        v[bfu_pkg::REG_EDGE_RIGHT] = $urandom_range(150, 320);
        v[bfu_pkg::REG_EDGE_BOTTOM] = $urandom_range(150, 320);
      end
      write_regs(v, p == 1);
      run_random(175);
      drain_flock();
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < BIRDS; k++) begin
      flock_px[k] = 0;
      flock_py[k] = 0;
      flock_vx[k] = 0;
      flock_vy[k] = 0;
      flock_valid[k] = 1'b0;
    end
    reg_val = '{75, 10, 200, 15, 68, 781, 362};
    // hold reset, then release it for good
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_defaults();
    test_regs_low();
    test_regs_high();
    test_regs_random();

    // every word is in: wait for the last bird, then a settle window
    drain_flock();
    if (errors == 0)
      $display("boids_flock_update_core test passed");
    else
      $display("boids_flock_update_core test failed");
    $finish;
  end

endmodule
